/* hdl/fcct_pkg.sv */
// Shared constants, codes and types of the four-channel counter/timer.
`default_nettype none
package fcct_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int CH_W         = 2;

   // request op codes
   localparam logic [2:0] OP_WRITE = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_TICK  = 3'd2;
   localparam logic [2:0] OP_PULSE = 3'd3;
   localparam logic [2:0] OP_ACK   = 3'd4;
   localparam logic [2:0] OP_CHECK = 3'd5;

   // control word bit positions
   localparam int CW_IRQ      = 7;
   localparam int CW_COUNTER  = 6;
   localparam int CW_PRE256   = 5;
   localparam int CW_TRIGWAIT = 3;
   localparam int CW_TCONST   = 2;
   localparam int CW_RESET    = 1;
   localparam int CW_CONTROL  = 0;

   localparam logic [7:0] CW_RESET_VALUE = 8'h02;

   // channel 2 wraps feed channel 3
   localparam logic [CH_W-1:0] CHAIN_SRC = 2'd2;
   localparam logic [CH_W-1:0] CHAIN_DST = 2'd3;
   localparam logic [CH_W-1:0] LAST_CH   = 2'd3;

   typedef struct packed {
      logic load;       // latch request
      logic exec;       // single-step op
      logic tick_load;  // start current tick channel
      logic tick_wrap;  // one wrap or final store
      logic pulse3;     // chained pulse into channel 3
      logic finish;     // load response register
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic pulse_chain;
      logic tick_skip;
      logic tick_last;
      logic n_neg;
      logic rsp_free;
   } status_type;

   typedef struct packed {
      logic [7:0]  cw;
      logic [15:0] dc;
      logic        wrap;
   } pulse_res_type;

endpackage
`default_nettype wire

/* hdl/fcct_if.sv */
// Request and response channel interfaces.
`default_nettype none
interface fcct_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [1:0] channel;
   logic [7:0] data;
   logic [9:0] clocks;

   modport source (output valid, output op, output channel, output data, output clocks,
                   input ready);
   modport sink (input valid, input op, input channel, input data, input clocks,
                 output ready);
endinterface

interface fcct_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [3:0] irq_pending;
   logic       int_valid;
   logic [1:0] int_channel;

   modport source (output valid, output read_data, output irq_pending, output int_valid,
                   output int_channel, input ready);
   modport sink (input valid, input read_data, input irq_pending, input int_valid,
                 input int_channel, output ready);
endinterface
`default_nettype wire

/* hdl/fcct_ctrl.sv */
// Sequencing state machine of the counter/timer.
`default_nettype none
module fcct_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire fcct_pkg::status_type status,
   output fcct_pkg::cmd_type         cmd
);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_EXEC      = 6'b000010,
      ST_TICK_LOAD = 6'b000100,
      ST_TICK_WRAP = 6'b001000,
      ST_PULSE3    = 6'b010000,
      ST_FINISH    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.is_tick)
               state_in = ST_TICK_LOAD;
            else if (status.pulse_chain)
               state_in = ST_PULSE3;
            else
               state_in = ST_FINISH;
         end
         ST_TICK_LOAD: begin
            cmd.tick_load = 1'b1;
            if (!status.tick_skip)
               state_in = ST_TICK_WRAP;
            else if (status.tick_last)
               state_in = ST_FINISH;
         end
         ST_TICK_WRAP: begin
            cmd.tick_wrap = 1'b1;
            if (!status.n_neg)
               state_in = status.tick_last ? ST_FINISH : ST_TICK_LOAD;
         end
         ST_PULSE3: begin
            cmd.pulse3 = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

endmodule
`default_nettype wire

/* hdl/fcct_dp.sv */
// Channel registers, tick arithmetic and response register.
`default_nettype none
module fcct_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [2:0]        req_op,
   input  wire logic [1:0]        req_channel,
   input  wire logic [7:0]        req_data,
   input  wire logic [9:0]        req_clocks,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_read_data,
   output logic [3:0]             rsp_irq_pending,
   output logic                   rsp_int_valid,
   output logic [1:0]             rsp_int_channel,
   input  wire fcct_pkg::cmd_type cmd,
   output fcct_pkg::status_type   status
);

   localparam int NCH = fcct_pkg::NUM_CHANNELS;

   logic [15:0] dc_ff [NCH];
   logic [15:0] dc_in [NCH];
   logic [7:0]  tc_ff [NCH];
   logic [7:0]  tc_in [NCH];
   logic [7:0]  cw_ff [NCH];
   logic [7:0]  cw_in [NCH];
   logic [7:0]  vb_ff, vb_in;
   logic [3:0]  pend_ff, pend_in;

   logic [2:0]  op_ff;
   logic [1:0]  ch_ff;
   logic [7:0]  data_ff;
   logic [9:0]  clocks_ff;

   logic [1:0]        tick_ch_ff, tick_ch_in;
   logic signed [17:0] n_ff, n_in;

   logic [7:0] res_rd_ff, res_rd_in;
   logic       res_valid_ff, res_valid_in;
   logic [1:0] res_ch_ff, res_ch_in;

   logic       rsp_valid_ff;
   logic [7:0] rsp_rd_ff;
   logic [3:0] rsp_pend_ff;
   logic       rsp_iv_ff;
   logic [1:0] rsp_ich_ff;

   fcct_pkg::pulse_res_type p_ch, p3;
   logic [13:0] dec;
   logic [17:0] wrap_add;
   logic [7:0]  cw_sel;

   function automatic logic stopped(input logic [7:0] cw);
      return cw[fcct_pkg::CW_TCONST] & cw[fcct_pkg::CW_RESET];
   endfunction

   function automatic fcct_pkg::pulse_res_type pulse_one(input logic [7:0]  cw,
                                                         input logic [15:0] dc,
                                                         input logic [7:0]  tc);
      fcct_pkg::pulse_res_type r;
      logic [15:0] d;
      r.cw   = cw;
      r.dc   = dc;
      r.wrap = 1'b0;
      d      = dc;
      if (cw[fcct_pkg::CW_COUNTER]) begin
         if (!stopped(cw)) begin
            if (dc[15:8] != 8'h00)
               d = dc - 16'h0100;
            if (d[15:8] == 8'h00) begin
               d      = {tc, 8'h00};
               r.wrap = 1'b1;
            end
            r.dc = d;
         end
      end else if (cw[fcct_pkg::CW_TRIGWAIT]) begin
         r.cw[fcct_pkg::CW_TRIGWAIT] = 1'b0;
      end
      return r;
   endfunction

   assign p_ch     = pulse_one(cw_ff[ch_ff], dc_ff[ch_ff], tc_ff[ch_ff]);
   assign p3       = pulse_one(cw_ff[fcct_pkg::CHAIN_DST], dc_ff[fcct_pkg::CHAIN_DST],
                               tc_ff[fcct_pkg::CHAIN_DST]);
   assign cw_sel   = cw_ff[tick_ch_ff];
   assign dec      = cw_sel[fcct_pkg::CW_PRE256] ? {4'b0000, clocks_ff} : {clocks_ff, 4'b0000};
   assign wrap_add = (tc_ff[tick_ch_ff] == 8'h00) ? 18'h10000
                                                  : {2'b00, tc_ff[tick_ch_ff], 8'h00};

   always_comb begin
      status.is_tick     = (op_ff == fcct_pkg::OP_TICK);
      status.pulse_chain = (op_ff == fcct_pkg::OP_PULSE) && (ch_ff == fcct_pkg::CHAIN_SRC)
                           && p_ch.wrap;
      status.tick_skip   = stopped(cw_sel) | cw_sel[fcct_pkg::CW_COUNTER];
      status.tick_last   = (tick_ch_ff == fcct_pkg::LAST_CH);
      status.n_neg       = n_ff[17];
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      dc_in        = dc_ff;
      tc_in        = tc_ff;
      cw_in        = cw_ff;
      vb_in        = vb_ff;
      pend_in      = pend_ff;
      tick_ch_in   = tick_ch_ff;
      n_in         = n_ff;
      res_rd_in    = res_rd_ff;
      res_valid_in = res_valid_ff;
      res_ch_in    = res_ch_ff;

      if (cmd.exec) begin
         res_rd_in    = 8'h00;
         res_valid_in = 1'b0;
         res_ch_in    = 2'd0;
         tick_ch_in   = 2'd0;
         case (op_ff)
            fcct_pkg::OP_WRITE: begin
               if (cw_ff[ch_ff][fcct_pkg::CW_TCONST]) begin
                  tc_in[ch_ff] = data_ff;
                  if (stopped(cw_ff[ch_ff]))
                     dc_in[ch_ff] = {data_ff - 8'd1, 8'h00};
                  cw_in[ch_ff][fcct_pkg::CW_TCONST] = 1'b0;
               end else if (data_ff[fcct_pkg::CW_CONTROL]) begin
                  cw_in[ch_ff] = data_ff;
                  if (data_ff[fcct_pkg::CW_RESET] && !data_ff[fcct_pkg::CW_TCONST])
                     dc_in[ch_ff] = {tc_ff[ch_ff] - 8'd1, 8'h00};
                  if (!data_ff[fcct_pkg::CW_IRQ])
                     pend_in[ch_ff] = 1'b0;
               end else if (ch_ff == 2'd0) begin
                  vb_in = data_ff;
               end
            end
            fcct_pkg::OP_READ: res_rd_in = dc_ff[ch_ff][15:8];
            fcct_pkg::OP_PULSE: begin
               cw_in[ch_ff] = p_ch.cw;
               dc_in[ch_ff] = p_ch.dc;
               if (p_ch.wrap && cw_ff[ch_ff][fcct_pkg::CW_IRQ])
                  pend_in[ch_ff] = 1'b1;
            end
            fcct_pkg::OP_ACK: pend_in[ch_ff] = 1'b0;
            fcct_pkg::OP_CHECK: begin
               for (int i = NCH - 1; i >= 0; i--) begin
                  if (pend_ff[i]) begin
                     res_valid_in = 1'b1;
                     res_ch_in    = 2'(i);
                     res_rd_in    = {vb_ff[7:3], 2'(i), 1'b0};
                  end
               end
            end
            default: ;
         endcase
      end

      if (cmd.tick_load) begin
         if (status.tick_skip)
            tick_ch_in = tick_ch_ff + 2'd1;
         else
            n_in = $signed({2'b00, dc_ff[tick_ch_ff]}) - $signed({4'b0000, dec});
      end

      if (cmd.tick_wrap) begin
         if (n_ff[17]) begin
            n_in = n_ff + $signed(wrap_add);
            if (cw_sel[fcct_pkg::CW_IRQ])
               pend_in[tick_ch_ff] = 1'b1;
         end else begin
            dc_in[tick_ch_ff] = n_ff[15:0];
            tick_ch_in        = tick_ch_ff + 2'd1;
         end
      end

      if ((cmd.tick_wrap && n_ff[17] && tick_ch_ff == fcct_pkg::CHAIN_SRC) || cmd.pulse3) begin
         cw_in[fcct_pkg::CHAIN_DST] = p3.cw;
         dc_in[fcct_pkg::CHAIN_DST] = p3.dc;
         if (p3.wrap && cw_ff[fcct_pkg::CHAIN_DST][fcct_pkg::CW_IRQ])
            pend_in[fcct_pkg::CHAIN_DST] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCH; i++) begin
            dc_ff[i] <= 16'h0000;
            tc_ff[i] <= 8'h00;
            cw_ff[i] <= fcct_pkg::CW_RESET_VALUE;
         end
         vb_ff        <= 8'h00;
         pend_ff      <= 4'h0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dc_ff   <= dc_in;
         tc_ff   <= tc_in;
         cw_ff   <= cw_in;
         vb_ff   <= vb_in;
         pend_ff <= pend_in;
         if (cmd.finish)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         ch_ff     <= req_channel;
         data_ff   <= req_data;
         clocks_ff <= req_clocks;
      end
      tick_ch_ff   <= tick_ch_in;
      n_ff         <= n_in;
      res_rd_ff    <= res_rd_in;
      res_valid_ff <= res_valid_in;
      res_ch_ff    <= res_ch_in;
      if (cmd.finish) begin
         rsp_rd_ff   <= res_rd_ff;
         rsp_pend_ff <= pend_ff;
         rsp_iv_ff   <= res_valid_ff;
         rsp_ich_ff  <= res_ch_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_rd_ff;
   assign rsp_irq_pending = rsp_pend_ff;
   assign rsp_int_valid   = rsp_iv_ff;
   assign rsp_int_channel = rsp_ich_ff;

endmodule
`default_nettype wire

/* hdl/four_channel_counter_timer.sv */
// Four-channel counter/timer: top level joining controller and datapath.
//
// Usage: one request on req_if (op, channel, data, clocks) gives exactly one
// response on rsp_if (read_data, irq_pending, int_valid, int_channel).
// A request is taken when req_if.valid and req_if.ready are both high;
// req_if.ready is high only while the sequencer is idle.
// Write, read, acknowledge, check, unused ops and pulses: the request is latched,
// then passes the execute and finish states, and finish loads the response.
// A pulse on channel 2 that wraps also passes a state for the chained pulse into
// channel 3.
// Tick: the channels are loaded in turn, and each channel that runs as a timer
// then goes through its wraps and a final store;
// the single shared subtract/reload unit handles one wrap per cycle.
// Responses sit in an output register; the next request is accepted while a
// response waits. If rsp_if.ready stays low, the following request finishes
// its work and then holds until the register frees up.
// Synchronous reset clears counts and time constants, sets every control
// word to the reset state, clears vector and pending bits, empties the
// response register.
`default_nettype none
module four_channel_counter_timer (
   input wire logic  clock,
   input wire logic  reset,
   fcct_req_if.sink  req_if,
   fcct_rsp_if.source rsp_if
);

   fcct_pkg::cmd_type    cmd;
   fcct_pkg::status_type status;

   fcct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fcct_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_if.op),
      .req_channel     (req_if.channel),
      .req_data        (req_if.data),
      .req_clocks      (req_if.clocks),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_read_data   (rsp_if.read_data),
      .rsp_irq_pending (rsp_if.irq_pending),
      .rsp_int_valid   (rsp_if.int_valid),
      .rsp_int_channel (rsp_if.int_channel),
      .cmd             (cmd),
      .status          (status)
   );

endmodule
`default_nettype wire

/* sim/tb_four_channel_counter_timer.sv */
// Self-checking testbench for the four-channel counter/timer: directed and random requests.
`default_nettype none
module tb_four_channel_counter_timer;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   localparam logic [7:0] M_IRQ      = 8'h01 << fcct_pkg::CW_IRQ;
   localparam logic [7:0] M_COUNTER  = 8'h01 << fcct_pkg::CW_COUNTER;
   localparam logic [7:0] M_PRE256   = 8'h01 << fcct_pkg::CW_PRE256;
   localparam logic [7:0] M_TRIGWAIT = 8'h01 << fcct_pkg::CW_TRIGWAIT;
   localparam logic [7:0] M_TCONST   = 8'h01 << fcct_pkg::CW_TCONST;
   localparam logic [7:0] M_RESET    = 8'h01 << fcct_pkg::CW_RESET;
   localparam logic [7:0] M_CTRL     = 8'h01 << fcct_pkg::CW_CONTROL;

   typedef struct packed {
      logic [7:0] read_data;
      logic [3:0] irq_pending;
      logic       int_valid;
      logic [1:0] int_channel;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   no_idle = 1'b0;
   int   mismatches = 0;

   fcct_req_if req();
   fcct_rsp_if rsp();

   four_channel_counter_timer DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   always #5ns clock = ~clock;

   // predicted channel state
   logic [15:0] cnt    [fcct_pkg::NUM_CHANNELS];
   logic [7:0]  tconst [fcct_pkg::NUM_CHANNELS];
   logic [7:0]  ctrl   [fcct_pkg::NUM_CHANNELS];
   logic [7:0]  vec_base;
   logic [3:0]  irq_mask;

   rsp_item_type predicted_rsp_q[$];
   rsp_item_type oldest_rsp;

   function automatic void pred_clear();
      for (int ch = 0; ch < fcct_pkg::NUM_CHANNELS; ch++) begin
         cnt[ch]    = 16'h0000;
         tconst[ch] = 8'h00;
         ctrl[ch]   = fcct_pkg::CW_RESET_VALUE;
      end
      vec_base = 8'h00;
      irq_mask = 4'h0;
   endfunction

   function automatic bit pred_halted(int ch);
      return ctrl[ch][fcct_pkg::CW_TCONST] && ctrl[ch][fcct_pkg::CW_RESET];
   endfunction

   function automatic void pred_raise(int ch);
      if (ctrl[ch][fcct_pkg::CW_IRQ])
         irq_mask[ch] = 1'b1;
   endfunction

   // one trigger pulse, true on wrap
   function automatic bit pred_trigger(int ch);
      if (ctrl[ch][fcct_pkg::CW_COUNTER]) begin
         if (pred_halted(ch))
            return 1'b0;
         if (cnt[ch] >= 16'h0100)
            cnt[ch] = cnt[ch] - 16'h0100;
         if (cnt[ch][15:8] == 8'h00) begin
            pred_raise(ch);
            cnt[ch] = {tconst[ch], 8'h00};
            return 1'b1;
         end
      end else if (ctrl[ch][fcct_pkg::CW_TRIGWAIT]) begin
         ctrl[ch][fcct_pkg::CW_TRIGWAIT] = 1'b0;
      end
      return 1'b0;
   endfunction

   function automatic void pred_advance(logic [9:0] clocks);
      int n;
      for (int ch = 0; ch < fcct_pkg::NUM_CHANNELS; ch++) begin
         if (pred_halted(ch) || ctrl[ch][fcct_pkg::CW_COUNTER])
            continue;
         n = int'(cnt[ch]) -
             (ctrl[ch][fcct_pkg::CW_PRE256] ? int'(clocks) : int'(clocks) * 16);
         while (n < 0) begin
            pred_raise(ch);
            if (ch == fcct_pkg::CHAIN_SRC)
               void'(pred_trigger(fcct_pkg::CHAIN_DST));
            n += (tconst[ch] == 8'h00) ? 65536 : int'(tconst[ch]) * 256;
         end
         cnt[ch] = n[15:0];
      end
   endfunction

   function automatic void pred_store(int ch, logic [7:0] val);
      if (ctrl[ch][fcct_pkg::CW_TCONST]) begin
         tconst[ch] = val;
         if (pred_halted(ch))
            cnt[ch] = {val - 8'd1, 8'h00};
         // only constant-follows drops; reset bit stays
         ctrl[ch][fcct_pkg::CW_TCONST] = 1'b0;
      end else if (val[fcct_pkg::CW_CONTROL]) begin
         ctrl[ch] = val;
         if (val[fcct_pkg::CW_RESET] && !val[fcct_pkg::CW_TCONST])
            cnt[ch] = {tconst[ch] - 8'd1, 8'h00};
         if (!val[fcct_pkg::CW_IRQ])
            irq_mask[ch] = 1'b0;
      end else if (ch == 0) begin
         vec_base = val;
      end
   endfunction

   function automatic rsp_item_type pred_step(logic [2:0] op, logic [1:0] ch,
                                              logic [7:0] data, logic [9:0] clocks);
      rsp_item_type r;
      r = '0;
      case (op)
         fcct_pkg::OP_WRITE: pred_store(ch, data);
         fcct_pkg::OP_READ:  r.read_data = cnt[ch][15:8];
         fcct_pkg::OP_TICK:  pred_advance(clocks);
         fcct_pkg::OP_PULSE: begin
            if (pred_trigger(ch) && ch == fcct_pkg::CHAIN_SRC)
               void'(pred_trigger(fcct_pkg::CHAIN_DST));
         end
         fcct_pkg::OP_ACK:   irq_mask[ch] = 1'b0;
         fcct_pkg::OP_CHECK: begin
            // walk downward so the lowest pending channel wins
            for (int i = fcct_pkg::NUM_CHANNELS - 1; i >= 0; i--) begin
               if (irq_mask[i]) begin
                  r.read_data   = {vec_base[7:3], 3'b000} + 8'(2 * i);
                  r.int_valid   = 1'b1;
                  r.int_channel = 2'(i);
               end
            end
         end
         default: ;
      endcase
      r.irq_pending = irq_mask;
      return r;
   endfunction

   function automatic void report_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val, act_val);
         mismatches++;
      end
   endfunction

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp.valid === 1'b1 && rsp.ready) begin
         if (predicted_rsp_q.size() == 0) begin
            $display("%0t: response mismatch: expected none, actual %h/%h/%b/%0d", $time,
                     rsp.read_data, rsp.irq_pending, rsp.int_valid, rsp.int_channel);
            mismatches++;
         end else begin
            oldest_rsp = predicted_rsp_q.pop_front();
            report_field("read_data", oldest_rsp.read_data, rsp.read_data);
            report_field("irq_pending", oldest_rsp.irq_pending, rsp.irq_pending);
            report_field("int_valid", oldest_rsp.int_valid, rsp.int_valid);
            report_field("int_channel", oldest_rsp.int_channel, rsp.int_channel);
            if ($isunknown({rsp.read_data, rsp.irq_pending, rsp.int_valid, rsp.int_channel}))
               report_field("unknown bits", 0, 1);
         end
      end
   end

   always @(posedge clock)
      rsp.ready <= no_idle || ($urandom_range(99) >= 29);

   task automatic send_request(input logic [2:0] op, input logic [1:0] ch,
                               input logic [7:0] data, input logic [9:0] clocks);
      while (!no_idle && $urandom_range(99) < 29) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.op      <= op;
      req.channel <= ch;
      req.data    <= data;
      req.clocks  <= clocks;
      @(posedge clock);
      while (!req.ready)
         @(posedge clock);
      predicted_rsp_q.push_back(pred_step(op, ch, data, clocks));
   endtask

   task automatic test_after_reset();
      for (int ch = 0; ch < fcct_pkg::NUM_CHANNELS; ch++)
         send_request(fcct_pkg::OP_READ, 2'(ch), 8'hFF, 10'h3FF);
      send_request(fcct_pkg::OP_CHECK, 2'd0, 8'h00, 10'h000);
      send_request(OP_SPARE6, 2'd3, 8'hA5, 10'h2AA);
      send_request(OP_SPARE7, 2'd1, 8'h5A, 10'h155);
   endtask

   task automatic test_vectors();
      send_request(fcct_pkg::OP_WRITE, 2'd0, 8'hF6, 10'h000);
      send_request(fcct_pkg::OP_WRITE, 2'd1, 8'h2E, 10'h000);
   endtask

   task automatic test_timer_wraps();
      send_request(fcct_pkg::OP_WRITE, 2'd0, M_IRQ | M_PRE256 | M_TCONST | M_RESET | M_CTRL,
                   10'h000);
      send_request(fcct_pkg::OP_WRITE, 2'd0, 8'h01, 10'h000);
      send_request(fcct_pkg::OP_TICK, 2'd0, 8'h00, 10'h3FF);
      send_request(fcct_pkg::OP_CHECK, 2'd0, 8'h00, 10'h000);
      send_request(fcct_pkg::OP_ACK, 2'd0, 8'h00, 10'h000);
      send_request(fcct_pkg::OP_TICK, 2'd0, 8'h00, 10'h000);
   endtask

   task automatic test_counter_chain();
      send_request(fcct_pkg::OP_WRITE, fcct_pkg::CHAIN_SRC,
                   M_IRQ | M_COUNTER | M_TCONST | M_RESET | M_CTRL, 10'h0);
      send_request(fcct_pkg::OP_WRITE, fcct_pkg::CHAIN_SRC, 8'h02, 10'h000);
      send_request(fcct_pkg::OP_WRITE, fcct_pkg::CHAIN_DST, M_IRQ | M_COUNTER | M_CTRL,
                   10'h000);
      send_request(fcct_pkg::OP_PULSE, fcct_pkg::CHAIN_SRC, 8'h00, 10'h000);
      send_request(fcct_pkg::OP_TICK, 2'd0, 8'h00, 10'h010);
      send_request(fcct_pkg::OP_CHECK, 2'd0, 8'h00, 10'h000);
      send_request(fcct_pkg::OP_PULSE, fcct_pkg::CHAIN_DST, 8'h00, 10'h000);
   endtask

   task automatic test_stopped_and_trigger();
      send_request(fcct_pkg::OP_WRITE, 2'd1, M_TRIGWAIT | M_TCONST | M_RESET | M_CTRL,
                   10'h000);
      send_request(fcct_pkg::OP_TICK, 2'd1, 8'h00, 10'h005);
      send_request(fcct_pkg::OP_PULSE, 2'd1, 8'h00, 10'h000);
      send_request(fcct_pkg::OP_WRITE, 2'd2, M_CTRL, 10'h000);
      send_request(fcct_pkg::OP_READ, 2'd1, 8'h00, 10'h000);
   endtask

   task automatic test_random_traffic(input int count, input bit idle_free);
      logic [2:0] op;
      logic [1:0] ch;
      logic [7:0] data;
      logic [9:0] clocks;
      int pick;
      no_idle = idle_free;
      repeat (count) begin
         ch     = 2'($urandom_range(3));
         data   = 8'($urandom);
         pick   = $urandom_range(99);
         clocks = (pick < 80) ? 10'($urandom_range(40)) :
                  (pick < 95) ? 10'($urandom_range(1023)) :
                  ($urandom_range(1) ? 10'h3FF : 10'h000);
         pick = $urandom_range(99);
         if (pick < 30) begin
            op = fcct_pkg::OP_WRITE;
            if (ctrl[ch][fcct_pkg::CW_TCONST]) begin
               if ($urandom_range(1))
                  data = 8'($urandom_range(8));
            end else begin
               pick = $urandom_range(99);
               if (pick < 70) begin
                  data[fcct_pkg::CW_CONTROL] = 1'b1;
                  if ($urandom_range(1))
                     data[fcct_pkg::CW_IRQ] = 1'b1;
               end else if (pick < 85) begin
                  data[fcct_pkg::CW_CONTROL] = 1'b0;
               end
            end
         end else if (pick < 43) op = fcct_pkg::OP_READ;
         else if (pick < 60) op = fcct_pkg::OP_TICK;
         else if (pick < 77) op = fcct_pkg::OP_PULSE;
         else if (pick < 85) op = fcct_pkg::OP_ACK;
         else if (pick < 96) op = fcct_pkg::OP_CHECK;
         else op = $urandom_range(1) ? OP_SPARE7 : OP_SPARE6;
         send_request(op, ch, data, clocks);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      req.valid   <= 1'b0;
      req.op      <= fcct_pkg::OP_READ;
      req.channel <= 2'd0;
      req.data    <= 8'h00;
      req.clocks  <= 10'h000;
      pred_clear();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_after_reset();
      test_vectors();
      test_timer_wraps();
      test_counter_chain();
      test_stopped_and_trigger();
      test_random_traffic(1300, 1'b0);
      test_random_traffic(300, 1'b1);
      req.valid <= 1'b0;
      while (predicted_rsp_q.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #50ms;
      $display("%0t: timeout with %0d responses outstanding", $time, predicted_rsp_q.size());
      $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire
